// ===== hdl/drcs_pkg.sv =====
// Package for the disk read command splitter: field widths, register
// indexes, microcode word layout and the microcode program.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drcs_pkg;

  localparam int unsigned BLOCK_W     = 28;
  localparam int unsigned TOTAL_W     = 12;
  localparam int unsigned SECT_W      = 6;
  localparam int unsigned HEADS_W     = 5;
  localparam int unsigned HEAD_W      = 4;
  localparam int unsigned CYL_W       = 16;
  localparam int unsigned DH_W        = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 6;
  localparam int unsigned DIV_STEPS   = BLOCK_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam int unsigned MAX_COMMANDS_DEF = 64;

  localparam logic [SECT_W-1:0]  SPT_RESET   = 6'd63;
  localparam logic [HEADS_W-1:0] HEADS_RESET = 5'd16;
  localparam logic [HEADS_W-1:0] HEADS_MAX   = 5'd16;
  localparam logic [DH_W-1:0]    DH_BASE     = 8'hA0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPT   = 2'd0,
    REG_HEADS = 2'd1,
    REG_DRIVE = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_DIV_SPT,
    STEP_LD_HEADS,
    STEP_DIV_HEADS,
    STEP_LD_CHS,
    STEP_EMIT
  } step_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_DIV_SPT,
    OP_LD_HEADS,
    OP_DIV_HEADS,
    OP_LD_CHS,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_ACC,
    COND_CNT_ZERO,
    COND_LEFT_ZERO,
    COND_RUN_END
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e tgt_true;
    step_e tgt_false;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_e pc);
    ucode_t w;
    case (pc)
      STEP_IDLE:      w = '{OP_IDLE,      COND_IN_ACC,    STEP_DIV_SPT,   STEP_IDLE};
      STEP_DIV_SPT:   w = '{OP_DIV_SPT,   COND_CNT_ZERO,  STEP_LD_HEADS,  STEP_DIV_SPT};
      STEP_LD_HEADS:  w = '{OP_LD_HEADS,  COND_ALWAYS,    STEP_DIV_HEADS, STEP_DIV_HEADS};
      STEP_DIV_HEADS: w = '{OP_DIV_HEADS, COND_CNT_ZERO,  STEP_LD_CHS,    STEP_DIV_HEADS};
      STEP_LD_CHS:    w = '{OP_LD_CHS,    COND_LEFT_ZERO, STEP_IDLE,      STEP_EMIT};
      STEP_EMIT:      w = '{OP_EMIT,      COND_RUN_END,   STEP_IDLE,      STEP_EMIT};
      default:        w = '{OP_IDLE,      COND_ALWAYS,    STEP_IDLE,      STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/drcs_if.sv =====
// Channel interfaces: read request in, read command out, register write.
// Depends on drcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface drcs_req_if import drcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BLOCK_W-1:0] start_block;
  logic [TOTAL_W-1:0] sector_total;
  modport source (output valid, start_block, sector_total, input ready);
  modport sink   (input valid, start_block, sector_total, output ready);
endinterface

interface drcs_cmd_if import drcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SECT_W-1:0] command_sectors;
  logic [SECT_W-1:0] start_sector;
  logic [HEAD_W-1:0] head_select;
  logic [CYL_W-1:0]  cylinder;
  logic [DH_W-1:0]   drive_head_byte;
  logic              truncated;
  logic              last_command;
  modport source (output valid, command_sectors, start_sector, head_select, cylinder,
                  drive_head_byte, truncated, last_command, input ready);
  modport sink   (input valid, command_sectors, start_sector, head_select, cylinder,
                  drive_head_byte, truncated, last_command, output ready);
endinterface

interface drcs_cfg_if import drcs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ===== hdl/disk_read_command_splitter.sv =====
// Disk read command splitter top level: microcoded sequencer over a
// shared restoring divider and a command emitter. Depends on drcs_pkg, drcs_if.
//
// A request (start block, sector count) is turned into cylinder/head/sector
// by two restoring divisions through one shared divide step (by sectors per
// track, then by head count), plus two load steps. Then one read command is
// issued per cycle, one per track segment, as long as the output register is
// drained; at most MAX_COMMANDS commands per request, the last flagged, and
// truncated set when sectors were left over. A zero sector count produces no
// command. One request is handled at a time; the next is taken once the last
// command sits in the output register. Registers are to be written through
// the config channel only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module disk_read_command_splitter import drcs_pkg::*; #(
  parameter int unsigned MAX_COMMANDS = MAX_COMMANDS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  drcs_cfg_if.sink    cfg_wr,
  drcs_req_if.sink    rd_req,
  drcs_cmd_if.source  rd_cmd
);

  localparam int unsigned CMD_W = $clog2(MAX_COMMANDS + 1);

  logic [SECT_W-1:0]  spt_q;
  logic [HEADS_W-1:0] heads_q;
  logic               drive_q;

  step_e  pc_q, pc_d;
  ucode_t uc;
  logic   cond_hit;

  logic [SECT_W-1:0]    rem_q, rem_d;
  logic [BLOCK_W-1:0]   quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [TOTAL_W-1:0]   left_q, left_d;
  logic [SECT_W-1:0]    pos_q, pos_d;
  logic [HEAD_W-1:0]    head_q, head_d;
  logic [CYL_W-1:0]     cyl_q, cyl_d;
  logic [CMD_W-1:0]     cmds_q, cmds_d;

  logic              ov_q, ov_d;
  logic [SECT_W-1:0] osec_q, osec_d, ostart_q, ostart_d;
  logic [HEAD_W-1:0] ohead_q, ohead_d;
  logic [CYL_W-1:0]  ocyl_q, ocyl_d;
  logic [DH_W-1:0]   odh_q, odh_d;
  logic              otrunc_q, otrunc_d, olast_q, olast_d;

  logic [SECT_W-1:0]  spt_eff;
  logic [HEADS_W-1:0] heads_eff;
  logic [SECT_W-1:0]  divisor;
  logic [SECT_W:0]    shifted;
  logic               ge;
  logic [SECT_W-1:0]  room, n;
  logic [TOTAL_W-1:0] new_left;
  logic [SECT_W:0]    new_pos;
  logic               track_end, cap, run_last, slot_free, emit;

  // Register file
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q   <= SPT_RESET;
      heads_q <= HEADS_RESET;
      drive_q <= 1'b0;
    end else if (cfg_wr.valid) begin
      case (cfg_reg_e'(cfg_wr.reg_index))
        REG_SPT:   spt_q   <= cfg_wr.wr_data[SECT_W-1:0];
        REG_HEADS: heads_q <= cfg_wr.wr_data[HEADS_W-1:0];
        REG_DRIVE: drive_q <= cfg_wr.wr_data[0];
        default: ;
      endcase
    end
  end

  assign spt_eff   = (spt_q == '0) ? SECT_W'(1) : spt_q;
  assign heads_eff = (heads_q == '0) ? HEADS_W'(1) :
                     (heads_q > HEADS_MAX) ? HEADS_MAX : heads_q;

  // Datapath
  assign uc       = ucode_rom(pc_q);
  assign divisor  = (uc.op == OP_DIV_SPT) ? spt_eff : {1'b0, heads_eff};
  assign shifted  = {rem_q, quo_q[BLOCK_W-1]};
  assign ge       = shifted >= {1'b0, divisor};

  assign room      = spt_eff - pos_q;
  assign n         = ({{(TOTAL_W-SECT_W){1'b0}}, room} <= left_q) ? room : left_q[SECT_W-1:0];
  assign new_left  = left_q - {{(TOTAL_W-SECT_W){1'b0}}, n};
  assign new_pos   = {1'b0, pos_q} + {1'b0, n};
  assign track_end = new_pos == {1'b0, spt_eff};
  assign cap       = (cmds_q + CMD_W'(1)) == CMD_W'(MAX_COMMANDS);
  assign run_last  = (new_left == '0) || cap;
  assign slot_free = !ov_q || rd_cmd.ready;
  assign emit      = (uc.op == OP_EMIT) && slot_free;

  assign rd_req.ready = (uc.op == OP_IDLE);

  always_comb begin
    case (uc.cond)
      COND_ALWAYS:    cond_hit = 1'b1;
      COND_IN_ACC:    cond_hit = rd_req.valid;
      COND_CNT_ZERO:  cond_hit = (cnt_q == '0);
      COND_LEFT_ZERO: cond_hit = (left_q == '0);
      COND_RUN_END:   cond_hit = emit && run_last;
      default:        cond_hit = 1'b1;
    endcase
    pc_d = cond_hit ? uc.tgt_true : uc.tgt_false;
  end

  always_comb begin
    rem_d    = rem_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    left_d   = left_q;
    pos_d    = pos_q;
    head_d   = head_q;
    cyl_d    = cyl_q;
    cmds_d   = cmds_q;
    ov_d     = ov_q && !rd_cmd.ready;
    osec_d   = osec_q;
    ostart_d = ostart_q;
    ohead_d  = ohead_q;
    ocyl_d   = ocyl_q;
    odh_d    = odh_q;
    otrunc_d = otrunc_q;
    olast_d  = olast_q;
    case (uc.op)
      OP_IDLE: begin
        if (rd_req.valid) begin
          rem_d  = '0;
          quo_d  = rd_req.start_block;
          cnt_d  = DIV_CNT_W'(DIV_STEPS - 1);
          left_d = rd_req.sector_total;
        end
      end
      OP_DIV_SPT, OP_DIV_HEADS: begin
        rem_d = ge ? SECT_W'(shifted - {1'b0, divisor}) : shifted[SECT_W-1:0];
        quo_d = {quo_q[BLOCK_W-2:0], ge};
        cnt_d = cnt_q - DIV_CNT_W'(1);
      end
      OP_LD_HEADS: begin
        pos_d = rem_q;
        rem_d = '0;
        cnt_d = DIV_CNT_W'(DIV_STEPS - 1);
      end
      OP_LD_CHS: begin
        head_d = rem_q[HEAD_W-1:0];
        cyl_d  = quo_q[CYL_W-1:0];
        cmds_d = '0;
      end
      OP_EMIT: begin
        if (emit) begin
          ov_d     = 1'b1;
          osec_d   = n;
          ostart_d = pos_q + SECT_W'(1);
          ohead_d  = head_q;
          ocyl_d   = cyl_q;
          odh_d    = DH_BASE | {3'b000, drive_q, 4'b0000} | {4'b0000, head_q};
          otrunc_d = (new_left != '0) && cap;
          olast_d  = run_last;
          left_d   = new_left;
          cmds_d   = cmds_q + CMD_W'(1);
          pos_d    = new_pos[SECT_W-1:0];
          if (track_end) begin
            pos_d = '0;
            if (({1'b0, head_q} + HEADS_W'(1)) >= heads_eff) begin
              head_d = '0;
              cyl_d  = cyl_q + CYL_W'(1);
            end else begin
              head_d = head_q + HEAD_W'(1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
      ov_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
    left_q   <= left_d;
    pos_q    <= pos_d;
    head_q   <= head_d;
    cyl_q    <= cyl_d;
    cmds_q   <= cmds_d;
    osec_q   <= osec_d;
    ostart_q <= ostart_d;
    ohead_q  <= ohead_d;
    ocyl_q   <= ocyl_d;
    odh_q    <= odh_d;
    otrunc_q <= otrunc_d;
    olast_q  <= olast_d;
  end

  assign rd_cmd.valid           = ov_q;
  assign rd_cmd.command_sectors = osec_q;
  assign rd_cmd.start_sector    = ostart_q;
  assign rd_cmd.head_select     = ohead_q;
  assign rd_cmd.cylinder        = ocyl_q;
  assign rd_cmd.drive_head_byte = odh_q;
  assign rd_cmd.truncated       = otrunc_q;
  assign rd_cmd.last_command    = olast_q;

  // Checks
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && run_last |=> pc_q == STEP_IDLE)
    else $error("run did not end after last command");

  a_pos_in_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == STEP_EMIT |-> pos_q < spt_eff)
    else $error("track position out of range");

  a_cmd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> n != '0)
    else $error("empty command issued");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == STEP_EMIT |-> cmds_q < CMD_W'(MAX_COMMANDS))
    else $error("command cap exceeded");

endmodule

`default_nettype wire

// ===== tb/tb_disk_read_command_splitter.sv =====
// Testbench for disk_read_command_splitter: directed and random read requests,
// commands checked against an in-bench CHS split predictor, random idling both sides.
// Depends on drcs_pkg, drcs_if and the RTL top level.
`timescale 1ns / 1ps

module tb_disk_read_command_splitter;
  import drcs_pkg::*;

  localparam int unsigned MAX_CMDS      = MAX_COMMANDS_DEF;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned SHOW_LIMIT    = 10;

  typedef struct packed {
    logic [SECT_W-1:0] sectors;
    logic [SECT_W-1:0] first_sector;
    logic [HEAD_W-1:0] head;
    logic [CYL_W-1:0]  cyl;
    logic [DH_W-1:0]   dh_byte;
    logic              trunc;
    logic              last;
  } read_cmd_t;

  logic clk_i;
  logic rst_ni;

  drcs_cfg_if cfg_wr ();
  drcs_req_if rd_req ();
  drcs_cmd_if rd_cmd ();

  disk_read_command_splitter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_wr (cfg_wr),
    .rd_req (rd_req),
    .rd_cmd (rd_cmd)
  );

  // geometry as the block should currently hold it
  logic [SECT_W-1:0]  geo_spt   = SPT_RESET;
  logic [HEADS_W-1:0] geo_heads = HEADS_RESET;
  logic               geo_drive = 1'b0;

  read_cmd_t expected_cmds[$];
  read_cmd_t exp_cmd;
  read_cmd_t got_cmd;
  int unsigned mismatches = 0;
  bit full_rate = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Linear block -> CHS, then one command per track segment, capped.
  function automatic void split_request(input logic [BLOCK_W-1:0] blk,
                                        input logic [TOTAL_W-1:0] total);
    int unsigned spt, heads, trk, pos, head, cyl, left, issued, room, n;
    read_cmd_t c;
    spt   = (geo_spt == '0) ? 1 : geo_spt;
    heads = (geo_heads == '0) ? 1 : ((geo_heads > HEADS_MAX) ? HEADS_MAX : geo_heads);
    trk    = blk / spt;
    pos    = blk % spt;
    head   = trk % heads;
    cyl    = (trk / heads) & 32'hFFFF;
    left   = total;
    issued = 0;
    while (left != 0 && issued < MAX_CMDS) begin
      room = spt - pos;
      n    = (room <= left) ? room : left;
      c.sectors      = n[SECT_W-1:0];
      c.first_sector = pos[SECT_W-1:0] + 1'b1;
      c.head         = head[HEAD_W-1:0];
      c.cyl          = cyl[CYL_W-1:0];
      c.dh_byte      = DH_BASE | {3'b000, geo_drive, head[HEAD_W-1:0]};
      left   -= n;
      pos    += n;
      issued += 1;
      if (pos == spt) begin
        pos = 0;
        if (head + 1 >= heads) begin
          head = 0;
          cyl  = (cyl + 1) & 32'hFFFF;
        end else begin
          head += 1;
        end
      end
      c.last  = (left == 0) || (issued >= MAX_CMDS);
      c.trunc = (left != 0) && (issued >= MAX_CMDS);
      expected_cmds.push_back(c);
    end
  endfunction

  task automatic note_mismatch(input string tag, input read_cmd_t e, input read_cmd_t g);
    mismatches++;
    if (mismatches <= SHOW_LIMIT)
      $display({"%0t %s: exp n=%0d s=%0d h=%0d c=%0d dh=%02h t=%0b l=%0b",
                " | got n=%0d s=%0d h=%0d c=%0d dh=%02h t=%0b l=%0b"},
               $realtime, tag, e.sectors, e.first_sector, e.head, e.cyl, e.dh_byte,
               e.trunc, e.last, g.sectors, g.first_sector, g.head, g.cyl, g.dh_byte,
               g.trunc, g.last);
  endtask

  // command checker
  always @(posedge clk_i) begin
    if (rst_ni && rd_cmd.valid && rd_cmd.ready) begin
      got_cmd = '{rd_cmd.command_sectors, rd_cmd.start_sector, rd_cmd.head_select,
                  rd_cmd.cylinder, rd_cmd.drive_head_byte, rd_cmd.truncated,
                  rd_cmd.last_command};
      if (expected_cmds.size() == 0) begin
        note_mismatch("unexpected command", '0, got_cmd);
      end else begin
        exp_cmd = expected_cmds.pop_front();
        if (got_cmd.sectors !== exp_cmd.sectors ||
            got_cmd.first_sector !== exp_cmd.first_sector ||
            got_cmd.head !== exp_cmd.head ||
            got_cmd.cyl !== exp_cmd.cyl ||
            got_cmd.dh_byte !== exp_cmd.dh_byte ||
            got_cmd.trunc !== exp_cmd.trunc ||
            got_cmd.last !== exp_cmd.last)
          note_mismatch("command mismatch", exp_cmd, got_cmd);
      end
    end
  end

  // command sink backpressure
  initial begin
    int unsigned hi, gap;
    rd_cmd.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (full_rate) begin
        rd_cmd.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        hi  = $urandom_range(1, 12);
        gap = rand_gap();
        rd_cmd.ready <= 1'b1;
        repeat (hi) @(posedge clk_i);
        if (gap > 0) begin
          rd_cmd.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // Leaves valid high on return; drain lowers it, as does the next call when it idles first.
  task automatic issue_request(input logic [BLOCK_W-1:0] blk, input logic [TOTAL_W-1:0] total);
    int unsigned gap;
    gap = full_rate ? 0 : rand_gap();
    if (gap > 0) begin
      rd_req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rd_req.valid        <= 1'b1;
    rd_req.start_block  <= blk;
    rd_req.sector_total <= total;
    do @(posedge clk_i); while (!rd_req.ready);
    split_request(blk, total);
  endtask

  task automatic drain_and_settle();
    rd_req.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    // a zero-length request still runs both divisions
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_one(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr.valid     <= 1'b1;
    cfg_wr.reg_index <= idx;
    cfg_wr.wr_data   <= data;
    do @(posedge clk_i); while (!cfg_wr.ready);
    case (idx)
      REG_SPT:   geo_spt   = data[SECT_W-1:0];
      REG_HEADS: geo_heads = data[HEADS_W-1:0];
      REG_DRIVE: geo_drive = data[0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] spt_val,
                              input logic [CFG_DATA_W-1:0] heads_val,
                              input logic [CFG_DATA_W-1:0] drive_val);
    drain_and_settle();
    write_one(REG_SPT, spt_val);
    write_one(REG_HEADS, heads_val);
    write_one(REG_DRIVE, drive_val);
    cfg_wr.valid <= 1'b0;
  endtask

  task automatic pick_request(output logic [BLOCK_W-1:0] blk, output logic [TOTAL_W-1:0] total);
    int unsigned spt;
    spt = (geo_spt == '0) ? 1 : geo_spt;
    case ($urandom_range(0, 7))
      0: blk = '0;
      1: blk = '1;
      2: blk = BLOCK_W'(spt * $urandom_range(1, 100000) - $urandom_range(1, spt));
      default: blk = BLOCK_W'($urandom());
    endcase
    case ($urandom_range(0, 15))
      0:       total = '0;
      1:       total = '1;
      2, 3:    total = TOTAL_W'($urandom_range(2000, 4095));
      4:       total = TOTAL_W'(spt * MAX_CMDS + $urandom_range(0, 2) - 1);
      default: total = TOTAL_W'($urandom_range(1, 150));
    endcase
  endtask

  task automatic test_reset_geometry();
    issue_request('0, 12'd1);
    issue_request(28'd62, 12'd2);
    issue_request(28'd1007, 12'd3);
    issue_request('0, '0);
    issue_request('0, 12'd4032);
    issue_request('0, 12'd4033);
    issue_request('0, '1);
    issue_request('1, '1);
    issue_request('1, 12'd1);
  endtask

  task automatic test_geometry_edges();
    set_geometry(6'd1, 6'd1, 6'd1);
    issue_request(28'd65535, 12'd3);
    issue_request('1, 12'd1);
    issue_request(28'd7, 12'd64);
    issue_request(28'd9, 12'd65);
    set_geometry(6'd0, 6'd0, 6'd0);
    issue_request(28'd5, 12'd2);
    issue_request(28'd100, 12'd70);
    set_geometry(6'd5, 6'd31, 6'd1);
    issue_request(28'd1000, 12'd40);
    issue_request(28'd79, 12'd7);
    set_geometry(6'd7, 6'h23, 6'h3E);
    issue_request(28'd20, 12'd30);
    issue_request(28'd41, 12'd1);
    set_geometry(6'h3F, 6'd16, 6'd1);
    issue_request(28'h8000000 - 28'd1, 12'd200);
  endtask

  task automatic test_back_to_back();
    logic [BLOCK_W-1:0] blk;
    logic [TOTAL_W-1:0] total;
    set_geometry(6'd3, 6'd2, 6'd1);
    full_rate = 1'b1;
    repeat (12) begin
      pick_request(blk, total);
      issue_request(blk, total);
    end
    drain_and_settle();
    full_rate = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [BLOCK_W-1:0] blk;
    logic [TOTAL_W-1:0] total;
    logic [CFG_DATA_W-1:0] spt_val, heads_val;
    repeat (6) begin
      case ($urandom_range(0, 5))
        0:       spt_val = 6'd1;
        1:       spt_val = 6'd63;
        2:       spt_val = 6'd0;
        3:       spt_val = CFG_DATA_W'($urandom_range(1, 8));
        default: spt_val = CFG_DATA_W'($urandom_range(1, 63));
      endcase
      case ($urandom_range(0, 5))
        0:       heads_val = 6'd1;
        1:       heads_val = 6'd16;
        2:       heads_val = CFG_DATA_W'($urandom_range(0, 63));
        default: heads_val = CFG_DATA_W'($urandom_range(1, 16));
      endcase
      set_geometry(spt_val, heads_val, CFG_DATA_W'($urandom_range(0, 63)));
      repeat (24) begin
        pick_request(blk, total);
        issue_request(blk, total);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    rd_req.valid        <= 1'b0;
    rd_req.start_block  <= '0;
    rd_req.sector_total <= '0;
    cfg_wr.valid        <= 1'b0;
    cfg_wr.reg_index    <= REG_SPT;
    cfg_wr.wr_data      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_geometry();
    test_geometry_edges();
    test_back_to_back();
    test_random_traffic();
    drain_and_settle();
    if (expected_cmds.size() != 0) begin
      mismatches += expected_cmds.size();
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/drcs_pkg.sv
hdl/drcs_if.sv
hdl/disk_read_command_splitter.sv
tb/tb_disk_read_command_splitter.sv
